>>> rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants for the signed integer to ASCII decimal block.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int VALUE_W    = 64;
  localparam int COLOR_W    = 24;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 20;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COLOR_W-1:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic [COLOR_W-1:0] char_color;
    logic               last_char;
  } out_item_t;

endpackage

>>> rtl/sitoa_stream_if.sv
// ----------------------------------------------------------------------------
// sitoa_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface sitoa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/signed_int_to_ascii_decimal.sv
// ----------------------------------------------------------------------------
// signed_int_to_ascii_decimal
// Converts a signed 64-bit integer to its decimal ASCII text, one character
// per result request, with an optional leading '-' and no leading zeros.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                              | accepted when
//  --------+-----+--------------------------------------+----------------------
//  req     | in  | value (s64), color (u24)             | req.valid & req.ready
//  chars   | out | character (7), char_color, last_char | chars.valid & ready
//
// One request is handled at a time. After acceptance the magnitude passes
// through a double-dabble shift register, one bit per cycle. Leading zero
// digits are then dropped one per cycle, and the characters leave one per
// cycle through the output register while the output is not stalled.
// A stalled output holds the emit sequence; reset is synchronous and clears
// only control state, and req.ready is high only between requests.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_decimal (
  input  logic                  clk,
  input  logic                  rst,
  sitoa_stream_if.sink          req,
  sitoa_stream_if.source        chars
);

  localparam int BCD_W = 4 * sitoa_pkg::NUM_DIGITS;
  localparam int BIT_W = $clog2(sitoa_pkg::VALUE_W);
  localparam int DIG_W = $clog2(sitoa_pkg::NUM_DIGITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  // Datapath registers (no reset needed).
  logic [sitoa_pkg::VALUE_W-1:0] mag;
  logic [BCD_W-1:0]              bcd;
  logic [sitoa_pkg::COLOR_W-1:0] color;
  logic                          sign_pending;
  logic [BIT_W-1:0]              bit_cnt;
  logic [DIG_W-1:0]              dig;

  // Output register.
  logic                  out_valid;
  sitoa_pkg::out_item_t  out_item;

  logic                  accept;
  logic                  emit_fire;
  logic [3:0]            top_digit;
  logic [BCD_W-1:0]      bcd_adj;

  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign chars.valid = out_valid;
  assign chars.data  = out_item;

  // Output slot is free when empty or being drained this cycle.
  assign emit_fire = (state == ST_EMIT) && (!out_valid || chars.ready);
  assign top_digit = bcd[BCD_W-1 -: 4];

  // Double-dabble correction: add 3 to every digit that is 5 or more.
  always_comb begin
    for (int d = 0; d < sitoa_pkg::NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == BIT_W'(sitoa_pkg::VALUE_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit != 4'd0 || dig == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire && !sign_pending && dig == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          // Unsigned magnitude; the most negative value maps onto itself.
          if (req.data.value[sitoa_pkg::VALUE_W-1]) begin
            mag <= ~req.data.value + 1'b1;
          end else begin
            mag <= req.data.value;
          end
          sign_pending <= req.data.value[sitoa_pkg::VALUE_W-1];
          color        <= req.data.color;
          bcd          <= '0;
          bit_cnt      <= '0;
          dig          <= DIG_W'(sitoa_pkg::NUM_DIGITS - 1);
        end
      end
      ST_CONV: begin
        // Shift the next magnitude bit into the corrected BCD word.
        bcd     <= {bcd_adj[BCD_W-2:0], mag[sitoa_pkg::VALUE_W-1]};
        mag     <= {mag[sitoa_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
      end
      ST_SKIP: begin
        // Drop one leading zero digit, keeping at least one.
        if (top_digit == 4'd0 && dig != '0) begin
          bcd <= {bcd[BCD_W-5:0], 4'd0};
          dig <= dig - 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_item.char_color <= color;
          if (sign_pending) begin
            out_item.character <= sitoa_pkg::CHAR_MINUS;
            out_item.last_char <= 1'b0;
            sign_pending       <= 1'b0;
          end else begin
            out_item.character <= sitoa_pkg::CHAR_ZERO
                                  + {{(sitoa_pkg::CHAR_W-4){1'b0}}, top_digit};
            out_item.last_char <= (dig == '0);
            bcd                <= {bcd[BCD_W-5:0], 4'd0};
            if (dig != '0) begin
              dig <= dig - 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV))
    else $error("accepted request did not start conversion");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.character == sitoa_pkg::CHAR_MINUS ||
                   (out_item.character >= sitoa_pkg::CHAR_ZERO &&
                    out_item.character <= sitoa_pkg::CHAR_NINE)))
    else $error("output character is not a digit or minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.character == sitoa_pkg::CHAR_MINUS) |-> !out_item.last_char)
    else $error("minus sign marked as last character");

  a_digit_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("emitted digit is not a valid BCD code");
`endif

endmodule
